@@ rtl/core/pressure_flow_factor_eval_core_defines.svh @@
// Assertion macros for the checker file of the flow factor evaluator.
`ifndef PRESSURE_FLOW_FACTOR_EVAL_CORE_DEFINES_SVH
`define PRESSURE_FLOW_FACTOR_EVAL_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PFFE_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("pffe assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define PFFE_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("pffe assertion failed");

// Next-cycle implication that also holds through reset.
`define PFFE_ASSERT_RST(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) (ante) |=> (cons)) \
    else $error("pffe reset assertion failed");

`endif

@@ rtl/core/pffe_pkg.sv @@
// Constants, coefficient tables and helper functions of the flow factor evaluator.
package pffe_pkg;

  localparam int unsigned TABLE_ENTRIES = 8;
  localparam int unsigned FRAC_BITS     = 16;
  localparam int unsigned SEG_BITS      = FRAC_BITS - 3;

  localparam int unsigned GAMMA_W     = 24;
  localparam int unsigned SEP_W       = 32;
  localparam int unsigned FLOW_W      = FRAC_BITS + 2;
  localparam int unsigned IN_TDATA_W  = ((SEP_W + 7) / 8) * 8;
  localparam int unsigned OUT_TDATA_W = ((FLOW_W + 7) / 8) * 8;

  localparam int unsigned TAB_ROWS = 16;
  localparam int unsigned ROW_W    = $clog2(TAB_ROWS);
  localparam int unsigned NE       = (TABLE_ENTRIES < 2) ? 2 :
                                     ((TABLE_ENTRIES > 16) ? 16 : TABLE_ENTRIES);

  localparam longint unsigned ONE_L = 64'd1 << FRAC_BITS;

  localparam int unsigned KW  = FRAC_BITS + 1;
  localparam int unsigned MW  = FRAC_BITS + 2;
  localparam int unsigned DW  = FRAC_BITS + 2;
  localparam int unsigned Q24_W = 26;

  localparam logic [GAMMA_W-1:0] ONE_G = GAMMA_W'(ONE_L);

  localparam logic [GAMMA_W-1:0] G_R9 = GAMMA_W'((ONE_L * 2 * 9 + 1) / 2);
  localparam logic [GAMMA_W-1:0] TAB_G [TAB_ROWS] = '{
    GAMMA_W'((ONE_L * 2 + 9) / 18),
    GAMMA_W'((ONE_L * 2 + 6) / 12),
    GAMMA_W'((ONE_L * 2 + 3) / 6),
    GAMMA_W'(ONE_L),
    GAMMA_W'(ONE_L + 1),
    GAMMA_W'(ONE_L * 3),
    GAMMA_W'(ONE_L * 6),
    G_R9, G_R9, G_R9, G_R9, G_R9, G_R9, G_R9, G_R9, G_R9
  };

  localparam logic [KW-1:0] C_LAST = KW'((ONE_L * 2 * 870 + 1000) / 2000);
  localparam logic [KW-1:0] TAB_C [TAB_ROWS] = '{
    KW'((ONE_L * 2 * 148 + 100) / 200),
    KW'((ONE_L * 2 * 138 + 100) / 200),
    KW'((ONE_L * 2 * 118 + 100) / 200),
    KW'((ONE_L * 2 * 90 + 100) / 200),
    KW'(0),
    KW'((ONE_L * 2 * 225 + 1000) / 2000),
    KW'((ONE_L * 2 * 520 + 1000) / 2000),
    C_LAST, C_LAST, C_LAST, C_LAST, C_LAST, C_LAST, C_LAST, C_LAST, C_LAST
  };

  localparam logic [KW-1:0] R_HI = KW'((ONE_L * 2 * 3 + 2) / 4);
  localparam logic [KW-1:0] TAB_R [TAB_ROWS] = '{
    KW'((ONE_L * 2 * 42 + 100) / 200),
    KW'((ONE_L * 2 * 42 + 100) / 200),
    KW'((ONE_L * 2 * 42 + 100) / 200),
    KW'((ONE_L * 2 * 56 + 100) / 200),
    R_HI, R_HI, R_HI, R_HI, R_HI, R_HI, R_HI, R_HI,
    R_HI, R_HI, R_HI, R_HI
  };

  localparam logic [Q24_W-1:0] EXP2_Q24 [9] = '{
    26'd16777216, 26'd18295684, 26'd19951585, 26'd21757357, 26'd23726566,
    26'd25873996, 26'd28215802, 26'd30769550, 26'd33554432
  };
  localparam logic [Q24_W-1:0] LOG2_Q24 [9] = '{
    26'd0, 26'd2850868, 26'd5401057, 26'd7707983, 26'd9814042,
    26'd11751428, 26'd13545168, 26'd15215099, 26'd16777216
  };
  localparam logic [Q24_W-1:0] LOG2E_Q24 = 26'd24204406;

  function automatic logic [MW-1:0] from_q24(logic [Q24_W-1:0] v);
    logic [Q24_W:0] t;
    t = {1'b0, v} + ((27'd1 << (24 - FRAC_BITS)) >> 1);
    return MW'(t >> (24 - FRAC_BITS));
  endfunction

  function automatic logic [MW-1:0] lerp9(logic [MW-1:0] a, logic [MW-1:0] b,
                                          logic [SEG_BITS-1:0] rem);
    logic [MW+SEG_BITS-1:0] p;
    p = (MW + SEG_BITS)'(b - a) * (MW + SEG_BITS)'(rem);
    return a + MW'(p >> SEG_BITS);
  endfunction

  function automatic logic [MW-1:0] exp2_interp(logic [FRAC_BITS-1:0] fr);
    logic [3:0] idx;
    idx = {1'b0, fr[FRAC_BITS-1 -: 3]};
    return lerp9(from_q24(EXP2_Q24[idx]), from_q24(EXP2_Q24[idx + 4'd1]),
                 fr[SEG_BITS-1:0]);
  endfunction

  function automatic logic [MW-1:0] log2_interp(logic [FRAC_BITS-1:0] fr);
    logic [3:0] idx;
    idx = {1'b0, fr[FRAC_BITS-1 -: 3]};
    return lerp9(from_q24(LOG2_Q24[idx]), from_q24(LOG2_Q24[idx + 4'd1]),
                 fr[SEG_BITS-1:0]);
  endfunction

endpackage

@@ rtl/core/pressure_flow_factor_eval_core.sv @@
// Top level of the pipelined pressure flow factor evaluator.
//
// The slave stream carries one signed Q16.16 surface separation per
// transaction in s_axis_tdata; the master stream returns the unsigned Q2.16
// pressure flow factor in the low bits of m_axis_tdata, one result for each
// input transaction and in the same order.
// The user writes the correlation length ratio gamma through cfg_wr_en_i and
// cfg_wr_data_i only while the pipeline holds no transactions (not enforced).
// The datapath is a 32-stage pipeline: ten arithmetic stages evaluate the two
// table entries that bracket gamma, twenty-one stages form the interpolation
// quotient one bit per stage, and a final stage saturates into the output
// register. One transaction is accepted in every cycle unless every stage
// holds a transaction and the receiver stalls.
// Each stage carries its own valid bit and advances whenever it is empty or
// the stage after it advances, so a stalled receiver fills empty stages first
// and s_axis_tready falls only when every stage holds a transaction.
// Reset clears all valid bits and sets gamma to 1.0.
module pressure_flow_factor_eval_core
  import pffe_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_wr_en_i,
  input  logic [GAMMA_W-1:0]     cfg_wr_data_i,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // separation[31:0]
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // flow_factor[17:0], zero padding above
  output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  localparam int unsigned HW    = SEP_W - 1;
  localparam int unsigned PBW   = $clog2(HW);
  localparam int unsigned XW    = FRAC_BITS + 7;
  localparam int unsigned YEW   = XW + 1;
  localparam int unsigned LW    = FRAC_BITS + 6;
  localparam int unsigned ZW    = XW + 2;
  localparam int unsigned NW    = ZW - FRAC_BITS;
  localparam int unsigned PWW   = MW + 8;
  localparam int unsigned TW    = KW + PWW - FRAC_BITS;
  localparam int unsigned YW    = FRAC_BITS + 5;
  localparam int unsigned PW    = YW + DW;
  localparam int unsigned QB    = YW;
  localparam int unsigned DBASE = 10;
  localparam int unsigned NSTG  = DBASE + QB + 1;

  localparam logic signed [SEP_W-1:0] HALF_S = SEP_W'(ONE_L >> 1);
  localparam logic signed [SEP_W-1:0] ONE_S  = SEP_W'(ONE_L);
  localparam logic [XW-1:0]           XLIM   = XW'(ONE_L * 64);
  localparam logic [MW-1:0]           LOG2E_Q = from_q24(LOG2E_Q24);
  localparam logic signed [YW+1:0]    OMAX_S = (YW + 2)'((ONE_L << 2) - 1);

  // Configuration and the bracket derived from it.
  logic [GAMMA_W-1:0] gamma_q;
  logic [ROW_W-1:0]   lo_idx, hi_idx;
  logic               pair;
  logic [KW-1:0]      cfg_c_q [2];
  logic [KW-1:0]      cfg_r_q [2];
  logic [DW-1:0]      w_q, d_q;
  logic               expo_q, glt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gamma_q <= ONE_G;
    end else if (cfg_wr_en_i) begin
      gamma_q <= cfg_wr_data_i;
    end
  end

  always_comb begin
    logic found;
    lo_idx = '0;
    hi_idx = '0;
    pair   = 1'b0;
    found  = 1'b0;
    if (gamma_q <= TAB_G[0]) begin
      lo_idx = '0;
    end else if (gamma_q >= TAB_G[NE-1]) begin
      lo_idx = ROW_W'(NE - 1);
    end else begin
      for (int i = 1; i < NE; i++) begin
        if (!found) begin
          if (gamma_q > TAB_G[i-1] && gamma_q < TAB_G[i]) begin
            lo_idx = ROW_W'(i - 1);
            hi_idx = ROW_W'(i);
            pair   = 1'b1;
            found  = 1'b1;
          end else if (gamma_q == TAB_G[i]) begin
            lo_idx = ROW_W'(i);
            found  = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cfg_c_q[0] <= TAB_C[lo_idx];
    cfg_c_q[1] <= TAB_C[hi_idx];
    cfg_r_q[0] <= TAB_R[lo_idx];
    cfg_r_q[1] <= TAB_R[hi_idx];
    w_q        <= pair ? DW'(gamma_q - TAB_G[lo_idx]) : '0;
    d_q        <= pair ? DW'(TAB_G[hi_idx] - TAB_G[lo_idx]) : DW'(1);
    expo_q     <= (gamma_q <= ONE_G);
    glt_q      <= (gamma_q < ONE_G);
  end

  // Stage handshake.
  logic [NSTG-1:0] vld_q, vld_in, en;

  always_comb begin
    en[NSTG-1] = !vld_q[NSTG-1] || m_axis_tready;
    for (int i = NSTG - 2; i >= 0; i--) begin
      en[i] = !vld_q[i] || en[i+1];
    end
    vld_in = {vld_q[NSTG-2:0], s_axis_tvalid};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int i = 0; i < NSTG; i++) begin
        if (en[i]) begin
          vld_q[i] <= vld_in[i];
        end
      end
    end
  end

  assign s_axis_tready = en[0];

  // Arithmetic stages.
  logic [SEP_W-1:0]         h0_q;
  logic [HW-1:0]            h1_q;
  logic [XW-1:0]            x2_q [2];
  logic [PBW-1:0]           p2_q;
  logic [FRAC_BITS-1:0]     fr2_q;
  logic [YEW-1:0]           y3_q [2];
  logic signed [LW-1:0]     l3_q;
  logic signed [ZW-1:0]     z4_q [2];
  logic [MW-1:0]            mant5_q [2];
  logic signed [NW-1:0]     n5_q [2];
  logic [PWW-1:0]           pw6_q [2];
  logic [YW-1:0]            ent7_q [2];
  logic [YW-1:0]            y08_q, y09_q;
  logic [YW-1:0]            mag8_q;
  logic                     neg8_q, neg9_q;
  logic [PW-1:0]            prod9_q;

  logic [HW-1:0]            h1_d;
  logic [XW-1:0]            x2_d [2];
  logic [PBW-1:0]           p2_d;
  logic [FRAC_BITS-1:0]     fr2_d;
  logic [YEW-1:0]           y3_d [2];
  logic signed [LW-1:0]     l3_d;
  logic signed [ZW-1:0]     z4_d [2];
  logic [MW-1:0]            mant5_d [2];
  logic signed [NW-1:0]     n5_d [2];
  logic [PWW-1:0]           pw6_d [2];
  logic [YW-1:0]            ent7_d [2];
  logic [YW-1:0]            mag8_d;
  logic                     neg8_d;
  logic [PW-1:0]            prod9_d;

  always_comb begin
    logic signed [SEP_W-1:0] hc;
    hc = $signed(h0_q);
    if (hc < HALF_S) begin
      hc = HALF_S;
    end
    if (glt_q && hc < ONE_S) begin
      hc = ONE_S;
    end
    h1_d = hc[HW-1:0];
  end

  always_comb begin
    logic [HW+KW-1:0] prod;
    logic [HW-1:0]    norm;
    for (int k = 0; k < 2; k++) begin
      prod = (HW + KW)'(h1_q) * (HW + KW)'(cfg_r_q[k]);
      if ((prod >> FRAC_BITS) > (HW + KW)'(XLIM)) begin
        x2_d[k] = XLIM;
      end else begin
        x2_d[k] = XW'(prod >> FRAC_BITS);
      end
    end
    p2_d = '0;
    for (int b = 0; b < HW; b++) begin
      if (h1_q[b]) begin
        p2_d = PBW'(b);
      end
    end
    norm  = h1_q << (PBW'(HW - 1) - p2_d);
    fr2_d = norm[HW-2 -: FRAC_BITS];
  end

  always_comb begin
    logic [XW+MW-1:0]     prod;
    logic signed [LW-1:0] ipart;
    for (int k = 0; k < 2; k++) begin
      prod    = (XW + MW)'(x2_q[k]) * (XW + MW)'(LOG2E_Q);
      y3_d[k] = YEW'(prod >> FRAC_BITS);
    end
    ipart = (LW'({1'b0, p2_q}) - LW'(FRAC_BITS)) <<< FRAC_BITS;
    l3_d  = ipart + LW'(log2_interp(fr2_q));
  end

  always_comb begin
    logic [LW-1:0]    mag;
    logic [LW+KW-1:0] prod;
    logic [LW-1:0]    t;
    mag = l3_q[LW-1] ? LW'(-l3_q) : LW'(l3_q);
    for (int k = 0; k < 2; k++) begin
      prod = (LW + KW)'(mag) * (LW + KW)'(cfg_r_q[k]);
      t    = LW'(prod >> FRAC_BITS);
      if (expo_q) begin
        z4_d[k] = -$signed(ZW'(y3_q[k]));
      end else if (l3_q[LW-1]) begin
        z4_d[k] = $signed(ZW'(t));
      end else begin
        z4_d[k] = -$signed(ZW'(t));
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 2; k++) begin
      mant5_d[k] = exp2_interp(z4_q[k][FRAC_BITS-1:0]);
      n5_d[k]    = NW'(z4_q[k] >>> FRAC_BITS);
    end
  end

  always_comb begin
    logic [NW-1:0] nn;
    logic [3:0]    sh;
    for (int k = 0; k < 2; k++) begin
      nn = NW'(-n5_q[k]);
      sh = (n5_q[k] > NW'(8)) ? 4'd8 : n5_q[k][3:0];
      if (!n5_q[k][NW-1]) begin
        pw6_d[k] = PWW'(mant5_q[k]) << sh;
      end else if (nn > NW'(62)) begin
        pw6_d[k] = '0;
      end else begin
        pw6_d[k] = PWW'(mant5_q[k]) >> nn;
      end
    end
  end

  always_comb begin
    logic [KW+PWW-1:0] prod;
    logic [TW-1:0]     term;
    for (int k = 0; k < 2; k++) begin
      prod = (KW + PWW)'(cfg_c_q[k]) * (KW + PWW)'(pw6_q[k]);
      term = TW'(prod >> FRAC_BITS);
      if (expo_q) begin
        ent7_d[k] = (term >= TW'(ONE_L)) ? '0 : YW'(TW'(ONE_L) - term);
      end else begin
        ent7_d[k] = YW'(TW'(ONE_L) + term);
      end
    end
  end

  always_comb begin
    logic signed [YW:0] diff;
    diff   = $signed({1'b0, ent7_q[1]}) - $signed({1'b0, ent7_q[0]});
    neg8_d = diff[YW];
    mag8_d = diff[YW] ? YW'(-diff) : YW'(diff);
  end

  assign prod9_d = PW'(mag8_q) * PW'(w_q);

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      h0_q <= s_axis_tdata[SEP_W-1:0];
    end
    if (en[1]) begin
      h1_q <= h1_d;
    end
    if (en[2]) begin
      x2_q  <= x2_d;
      p2_q  <= p2_d;
      fr2_q <= fr2_d;
    end
    if (en[3]) begin
      y3_q <= y3_d;
      l3_q <= l3_d;
    end
    if (en[4]) begin
      z4_q <= z4_d;
    end
    if (en[5]) begin
      mant5_q <= mant5_d;
      n5_q    <= n5_d;
    end
    if (en[6]) begin
      pw6_q <= pw6_d;
    end
    if (en[7]) begin
      ent7_q <= ent7_d;
    end
    if (en[8]) begin
      y08_q  <= ent7_q[0];
      mag8_q <= mag8_d;
      neg8_q <= neg8_d;
    end
    if (en[9]) begin
      y09_q   <= y08_q;
      neg9_q  <= neg8_q;
      prod9_q <= prod9_d;
    end
  end

  // Restoring divider, one quotient bit per stage, most significant first.
  logic [PW-1:0] rem_q [QB];
  logic [QB-1:0] quo_q [QB];
  logic [YW-1:0] dy0_q [QB];
  logic          dneg_q [QB];
  logic [PW-1:0] rem_d [QB];
  logic [QB-1:0] quo_d [QB];

  always_comb begin
    logic [PW-1:0] rin, dsh;
    logic [QB-1:0] qin;
    for (int j = 0; j < QB; j++) begin
      rin = (j == 0) ? prod9_q : rem_q[(j == 0) ? 0 : j - 1];
      qin = (j == 0) ? '0 : quo_q[(j == 0) ? 0 : j - 1];
      dsh = PW'(d_q) << (QB - 1 - j);
      rem_d[j] = rin;
      quo_d[j] = qin;
      if (rin >= dsh) begin
        rem_d[j] = rin - dsh;
        quo_d[j][QB-1-j] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int j = 0; j < QB; j++) begin
      if (en[DBASE+j]) begin
        rem_q[j]  <= rem_d[j];
        quo_q[j]  <= quo_d[j];
        dy0_q[j]  <= (j == 0) ? y09_q : dy0_q[(j == 0) ? 0 : j - 1];
        dneg_q[j] <= (j == 0) ? neg9_q : dneg_q[(j == 0) ? 0 : j - 1];
      end
    end
  end

  // Final correction and saturation.
  logic [FLOW_W-1:0] flow_q, flow_d;

  always_comb begin
    logic signed [YW+1:0] q, y;
    q = $signed((YW + 2)'(quo_q[QB-1]));
    if (dneg_q[QB-1]) begin
      q = -q;
    end
    y = $signed((YW + 2)'(dy0_q[QB-1])) + q;
    if (y < 0) begin
      flow_d = '0;
    end else if (y > OMAX_S) begin
      flow_d = FLOW_W'(OMAX_S);
    end else begin
      flow_d = FLOW_W'(y);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[NSTG-1]) begin
      flow_q <= flow_d;
    end
  end

  assign m_axis_tvalid = vld_q[NSTG-1];
  assign m_axis_tdata  = OUT_TDATA_W'(flow_q);

endmodule

@@ rtl/core/pffe_checker.sv @@
// Port-level checker for the flow factor evaluator, bound to its top level.
`include "pressure_flow_factor_eval_core_defines.svh"

module pffe_checker
  import pffe_pkg::*;
(
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   s_axis_tready,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  `PFFE_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
  `PFFE_ASSERT_NXT(a_out_stable, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))
  `PFFE_ASSERT_IMP(a_ready_when_empty, !m_axis_tvalid, s_axis_tready)
  `PFFE_ASSERT_IMP(a_pad_zero, m_axis_tvalid, m_axis_tdata[OUT_TDATA_W-1:FLOW_W] == '0)
  `PFFE_ASSERT_RST(a_reset_quiet, !rst_ni, !m_axis_tvalid)

endmodule

bind pressure_flow_factor_eval_core pffe_checker u_pffe_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
